### design/kcf_pkg.sv
package kcf_pkg;

   // Widths fixed by the transaction fields and the register.
   localparam int VERTEX_W = 6;
   localparam int WEIGHT_W = 16;
   localparam int COST_W   = 22;
   localparam int COUNT_W  = 6;
   localparam int VCOUNT_W = 7;

   localparam int MAX_VERTICES_DEFAULT = 64;

   // Saturation limits of the running totals.
   localparam logic [COUNT_W-1:0]       COUNT_MAX = '1;
   localparam logic signed [COST_W:0]   COST_MAX  = (COST_W+1)'((1 << (COST_W - 1)) - 1);
   localparam logic signed [COST_W:0]   COST_MIN  = -(COST_W+1)'(1 << (COST_W - 1));

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_VERTEX_COUNT_ADDR = CSR_ADDR_W'(0);

endpackage

### design/kcf_req_if.sv
interface kcf_req_if;

   logic                                valid;
   logic                                ready;
   logic                                first_edge;
   logic [kcf_pkg::VERTEX_W-1:0]        tail_vertex;
   logic [kcf_pkg::VERTEX_W-1:0]        head_vertex;
   logic signed [kcf_pkg::WEIGHT_W-1:0] edge_weight;

   modport source (output valid, first_edge, tail_vertex, head_vertex, edge_weight,
                   input ready);
   modport sink   (input valid, first_edge, tail_vertex, head_vertex, edge_weight,
                   output ready);

endinterface

### design/kcf_rsp_if.sv
interface kcf_rsp_if;

   logic                              valid;
   logic                              ready;
   logic                              accepted;
   logic [kcf_pkg::COUNT_W-1:0]       tree_edge_count;
   logic signed [kcf_pkg::COST_W-1:0] total_cost;
   logic                              complete;

   modport source (output valid, accepted, tree_edge_count, total_cost, complete,
                   input ready);
   modport sink   (input valid, accepted, tree_edge_count, total_cost, complete,
                   output ready);

endinterface

### design/kruskal_cycle_filter_core.sv
// Union-find cycle filter for a Kruskal spanning tree. Edges arrive one per
// request transaction in ascending weight order; each produces exactly one
// response transaction that tells whether the edge joined two trees, together
// with the running edge count, the saturated running cost and the completion
// flag. A request with first_edge set starts a new graph. The block handles one
// edge at a time: an edge that is walked follows the parent links from the tail
// vertex and then from the head vertex to their roots, each link step being one
// read of the parent memory in CHECK followed by FETCH, which takes its
// registered data; the edge then passes through LINK and FINISH. An edge that is
// skipped (tree already complete, or a vertex out of range) goes straight from
// acceptance to FINISH. A finished response waits in its output register, and
// the next request is taken meanwhile. The user must write vertex_count through
// the register port only while the block is idle; the block does not enforce it.

module kruskal_cycle_filter_core #(
   parameter int MAX_VERTICES = kcf_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,

   kcf_req_if.sink                         req_bus,
   kcf_rsp_if.source                       rsp_bus,

   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [kcf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [kcf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [kcf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   // Width of a vertex index into the forest.
   localparam int VIDX_W = $clog2(MAX_VERTICES);
   // Common width for widening or narrowing an incoming vertex number.
   localparam int EXT_W  = (VIDX_W > kcf_pkg::VERTEX_W) ? VIDX_W : kcf_pkg::VERTEX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FETCH,
      ST_LINK,
      ST_FINISH
   } state_type;

   // ---------------------------------------------------------------------
   // Register port. The only register is vertex_count; pready is constant.
   // ---------------------------------------------------------------------
   logic [kcf_pkg::VCOUNT_W-1:0] vertex_count_ff, vertex_count_in;
   logic                         csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr == kcf_pkg::CSR_VERTEX_COUNT_ADDR);
   assign prdata    = (paddr == kcf_pkg::CSR_VERTEX_COUNT_ADDR) ?
                      kcf_pkg::CSR_DATA_W'(vertex_count_ff) : '0;

   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (csr_write) begin
         vertex_count_in = pwdata[kcf_pkg::VCOUNT_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Forest storage. The parent memory has one read and one write port and
   // a registered read; its entries need no reset because an entry is only
   // followed once its root bit has been cleared, which happens together
   // with the write. The root bits are flip-flops that a new graph sets at
   // once.
   // ---------------------------------------------------------------------
   logic [VIDX_W-1:0]       parent_mem [MAX_VERTICES];
   logic [VIDX_W-1:0]       mem_q_ff;
   logic [MAX_VERTICES-1:0] is_root_ff, is_root_in;

   // Sequencer state and the per-edge working registers.
   state_type                            state_ff, state_in;
   logic [VIDX_W-1:0]                    cur_ff, cur_in;
   logic [VIDX_W-1:0]                    head_idx_ff, head_idx_in;
   logic [VIDX_W-1:0]                    root_tail_ff, root_tail_in;
   logic                                 walk_head_ff, walk_head_in;
   logic signed [kcf_pkg::WEIGHT_W-1:0]  weight_ff, weight_in;
   logic                                 accepted_ff, accepted_in;

   // Graph totals.
   logic [kcf_pkg::COUNT_W-1:0]          count_ff, count_in;
   logic signed [kcf_pkg::COST_W-1:0]    cost_ff, cost_in;
   logic                                 done_ff, done_in;

   // Response register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_accepted_ff, rsp_accepted_in;
   logic [kcf_pkg::COUNT_W-1:0]          rsp_count_ff, rsp_count_in;
   logic signed [kcf_pkg::COST_W-1:0]    rsp_cost_ff, rsp_cost_in;
   logic                                 rsp_complete_ff, rsp_complete_in;

   // Incoming vertex numbers resized to index width, and their range check.
   logic [EXT_W-1:0]  tail_ext, head_ext;
   logic [VIDX_W-1:0] tail_idx, head_idx;
   logic              in_range;
   logic              req_fire;
   logic              link_now;

   // Arithmetic used when an edge is linked.
   logic [kcf_pkg::COUNT_W-1:0]       count_next;
   logic [kcf_pkg::VCOUNT_W-1:0]      count_plus_one;
   logic signed [kcf_pkg::COST_W:0]   cost_sum;
   logic signed [kcf_pkg::COST_W-1:0] cost_next;

   assign tail_ext = EXT_W'(req_bus.tail_vertex);
   assign head_ext = EXT_W'(req_bus.head_vertex);
   assign tail_idx = tail_ext[VIDX_W-1:0];
   assign head_idx = head_ext[VIDX_W-1:0];
   assign in_range = (32'(req_bus.tail_vertex) < 32'(MAX_VERTICES))
                     && (32'(req_bus.head_vertex) < 32'(MAX_VERTICES));

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // In the link step cur_ff holds the head's root.
   assign link_now = (state_ff == ST_LINK) && (cur_ff != root_tail_ff);

   assign count_next     = (count_ff == kcf_pkg::COUNT_MAX) ? count_ff : count_ff + 1'b1;
   // The tree is complete when count >= vertex_count - 1, i.e. count + 1 >= vertex_count.
   assign count_plus_one = kcf_pkg::VCOUNT_W'(count_next) + 1'b1;
   assign cost_sum       = (kcf_pkg::COST_W+1)'(cost_ff) + (kcf_pkg::COST_W+1)'(weight_ff);
   always_comb begin
      if (cost_sum > kcf_pkg::COST_MAX) begin
         cost_next = kcf_pkg::COST_MAX[kcf_pkg::COST_W-1:0];
      end else if (cost_sum < kcf_pkg::COST_MIN) begin
         cost_next = kcf_pkg::COST_MIN[kcf_pkg::COST_W-1:0];
      end else begin
         cost_next = cost_sum[kcf_pkg::COST_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer. One walker runs the tail's root search, then the head's:
   // CHECK tests the root bit of the current vertex and starts a memory
   // read, FETCH moves to the parent that the read returned.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      cur_in          = cur_ff;
      head_idx_in     = head_idx_ff;
      root_tail_in    = root_tail_ff;
      walk_head_in    = walk_head_ff;
      weight_in       = weight_ff;
      accepted_in     = accepted_ff;
      is_root_in      = is_root_ff;
      count_in        = count_ff;
      cost_in         = cost_ff;
      done_in         = done_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_cost_in     = rsp_cost_ff;
      rsp_complete_in = rsp_complete_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_in       = tail_idx;
               head_idx_in  = head_idx;
               weight_in    = req_bus.edge_weight;
               walk_head_in = 1'b0;
               accepted_in  = 1'b0;
               if (req_bus.first_edge) begin
                  is_root_in = '1;
                  count_in   = '0;
                  cost_in    = '0;
                  done_in    = 1'b0;
               end
               if ((done_ff && !req_bus.first_edge) || !in_range) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (is_root_ff[cur_ff]) begin
               if (walk_head_ff) begin
                  state_in = ST_LINK;
               end else begin
                  root_tail_in = cur_ff;
                  cur_in       = head_idx_ff;
                  walk_head_in = 1'b1;
               end
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cur_in   = mem_q_ff;
            state_in = ST_CHECK;
         end
         ST_LINK: begin
            if (link_now) begin
               is_root_in[cur_ff] = 1'b0;
               accepted_in        = 1'b1;
               count_in           = count_next;
               cost_in            = cost_next;
               if (count_plus_one >= vertex_count_ff) begin
                  done_in = 1'b1;
               end
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = accepted_ff;
               rsp_count_in    = count_ff;
               rsp_cost_in     = cost_ff;
               rsp_complete_in = done_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         is_root_ff      <= '1;
         count_ff        <= '0;
         cost_ff         <= '0;
         done_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         vertex_count_ff <= '0;
      end else begin
         state_ff        <= state_in;
         is_root_ff      <= is_root_in;
         count_ff        <= count_in;
         cost_ff         <= cost_in;
         done_ff         <= done_in;
         rsp_valid_ff    <= rsp_valid_in;
         vertex_count_ff <= vertex_count_in;
      end
      cur_ff          <= cur_in;
      head_idx_ff     <= head_idx_in;
      root_tail_ff    <= root_tail_in;
      walk_head_ff    <= walk_head_in;
      weight_ff       <= weight_in;
      accepted_ff     <= accepted_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_cost_ff     <= rsp_cost_in;
      rsp_complete_ff <= rsp_complete_in;
   end

   // Parent memory: the head's root is hung under the tail's root.
   always_ff @(posedge clock) begin
      if (link_now) begin
         parent_mem[cur_ff] <= root_tail_ff;
      end
      mem_q_ff <= parent_mem[cur_ff];
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.accepted        = rsp_accepted_ff;
   assign rsp_bus.tree_edge_count = rsp_count_ff;
   assign rsp_bus.total_cost      = rsp_cost_ff;
   assign rsp_bus.complete        = rsp_complete_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // A parent is only taken after the walker has issued its read.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> $past(state_ff == ST_CHECK))
      else $error("parent taken without a preceding read");

   // The edge count only falls when a new graph is started.
   assert property (@(posedge clock) disable iff (reset)
      !(req_fire && req_bus.first_edge) |=> (count_ff >= $past(count_ff)))
      else $error("edge count fell within a graph");

   // A response is only raised from the finishing step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finishing step");

   // An accepted edge is always counted.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_accepted_ff) |-> (rsp_count_ff != '0))
      else $error("accepted edge reported with a zero count");

endmodule
